>>> rtl/rwlf_pkg.sv
// Shared constants, types and helper functions for the robust weighted line fit.
// No dependencies; every rwlf module but rwlf_ram imports this package.
package rwlf_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int VAL_W   = 32;
	localparam int WGT_W   = 24;
	localparam int CFG_W   = 4;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 64;
	localparam int SW_W    = WGT_W + CNT_W;
	localparam int ACC_W   = 128;
	localparam int DIV_W   = 128;
	localparam int ITER_W  = 8;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int F_W     = 50;
	localparam int SCALE_W = VAL_W + 3;
	localparam int PH_W    = 4;

	localparam logic [CFG_W-1:0]  RESET_PASSES = CFG_W'(3);
	localparam logic [ITER_W-1:0] ITER_FULL    = ITER_W'(DIV_W);
	localparam logic [ITER_W-1:0] ITER_FRAC    = ITER_W'(64);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SUM   = 11'b000_0000_0010,
		ST_MEAN  = 11'b000_0000_0100,
		ST_VAR   = 11'b000_0000_1000,
		ST_SLOPE = 11'b000_0001_0000,
		ST_ICPT  = 11'b000_0010_0000,
		ST_RESID = 11'b000_0100_0000,
		ST_MSTEP = 11'b000_1000_0000,
		ST_MCNT  = 11'b001_0000_0000,
		ST_BISQ  = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [VAL_W-1:0]  quo;
		logic              ovf;
	} div_rsp_t;

	function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
	endfunction

	// signed quotient from magnitude quotient, saturated to 32 bits
	function automatic logic [VAL_W-1:0] div_sat(input logic neg, input logic [VAL_W-1:0] quo,
		input logic ovf);
		if (ovf || quo[VAL_W-1]) begin
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? (~quo + VAL_W'(1)) : quo;
	endfunction

	function automatic logic [VAL_W-1:0] sat_f(input logic [F_W-1:0] v);
		if (&v[F_W-1:VAL_W-1] || ~|v[F_W-1:VAL_W-1]) begin
			return v[VAL_W-1:0];
		end
		return v[F_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic logic [F_W-1:0] sext_f(input logic [VAL_W-1:0] v);
		return {{(F_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

endpackage

>>> rtl/rwlf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module rwlf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rwlf_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on rwlf_pkg for operand widths.
module rwlf_mul import rwlf_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

>>> rtl/rwlf_div.sv
// Shared restoring divider, one quotient bit per cycle, 32-bit quotient plus overflow.
// Depends on rwlf_pkg for the request and response structs.
module rwlf_div import rwlf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q, done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DIV_W-1:0]  num_q, den_q, rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic              ovf_q;
	logic [DIV_W:0]    rem_sh, rem_df;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_W-1]};
		rem_df = rem_sh - {1'b0, den_q};
		ge     = !rem_df[DIV_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= ge ? rem_df[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[VAL_W-1];
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quo: quo_q, ovf: ovf_q};

endmodule

>>> rtl/robust_weighted_line_fit_unit.sv
// Robust weighted line fit: iteratively reweighted least squares with a Tukey bisquare.
// Top level; uses rwlf_pkg, rwlf_ram, rwlf_mul and rwlf_div.
//
// Usage:
//  - Slave stream carries one point per item: x, y (Q16.16) and weight (Q8.16).
//    s_tlast marks the final point of a set and starts the fit. Points load at one
//    item per cycle into on-chip stores; points past MAX_POINTS are dropped.
//  - While fitting, s_tready stays low. One shared multiplier and one shared
//    bit-serial divider do all arithmetic under a small sequencer:
//      plain fit      two sums walks and three 128-bit divides
//      each pass      adds a residual walk, a median search of up to 32 steps
//                     (twice for even n), a bisquare walk (one divide per point
//                     below the scale) and another plain fit.
//    Total latency is dominated by the bisquare divider and the median search.
//  - Master stream returns intercept and slope in m_tdata and the status flag in
//    m_tuser. The result sits in an output register: if the receiver stalls, the
//    block holds it and waits before presenting the next one; loading the next set
//    goes on meanwhile.
//  - cfg_we writes robust_passes (reset 3); write only while idle.
//  - Reset returns to idle with an empty set; the stores are not cleared, since
//    only written entries are read.
module robust_weighted_line_fit_unit import rwlf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // x_value[31:0], y_value[63:32], weight[87:64]
	input  logic              s_tlast,   // last_point
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // intercept[31:0], slope[63:32]
	output logic              m_tuser,   // fit_status
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data
);

	// control
	state_t            state_q;
	logic [PH_W-1:0]   ph_q;
	logic [CNT_W-1:0]  i_q, n_q, cnt_q, k_q;
	logic [CFG_W-1:0]  passes_q, left_q;
	logic              use_ww_q, ok_q, second_q;
	logic              m_tvalid_q;

	// datapath
	logic [VAL_W-1:0]   x_q, y_q, xm_q, ym_q, a_q, b_q, dxm_q, dym_q, r_q;
	logic [VAL_W-1:0]   lo_q, hi_q, mid_q, v1_q;
	logic [WGT_W-1:0]   w_q, pw_q;
	logic               dxn_q, dyn_q, neg_q;
	logic [56:0]        wdx_q;
	logic [ACC_W-1:0]   acc0_q, acc1_q;
	logic [SW_W-1:0]    sw_q;
	logic [F_W-1:0]     f_q;
	logic [MUL_W-1:0]   t_q;
	logic [SCALE_W-1:0] scale_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tuser_q;

	// stores
	logic [IDX_W-1:0] rd_addr, ld_addr;
	logic             ld_we, res_we, ww_we;
	logic [VAL_W-1:0] x_rd, y_rd, res_rd, res_wd;
	logic [WGT_W-1:0] pw_rd, ww_rd, ww_wd, w_rd;

	// shared units
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// helpers
	logic               s_acc, last_pt, le_c, sm_neg, r_big;
	logic [CNT_W-1:0]   i_nx, cnt_nx, k_init;
	logic [VAL_W:0]     dx_c, dy_c, mid_sum, med_sum;
	logic [VAL_W-1:0]   med_c;
	logic [SCALE_W-1:0] scale_c;
	logic [F_W-1:0]     sm_c, icpt_c, f_c, d_c, d_abs;
	logic [VAL_W-1:0]   r_c;
	logic [ACC_W-1:0]   acc0_abs, acc1_abs, sxy_sh, sxy_abs, acc_sh, acc_term, acc_sum;
	logic               acc_en, acc_sel, acc_hi, acc_neg;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign rd_addr = i_q[IDX_W-1:0];
	assign ld_addr = n_q[IDX_W-1:0];
	assign ld_we   = s_acc && (n_q < CNT_W'(MAX_POINTS));
	assign w_rd    = use_ww_q ? ww_rd : pw_rd;

	rwlf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk, .we(ld_we), .waddr(ld_addr), .wdata(s_tdata[31:0]), .raddr(rd_addr), .rdata(x_rd));
	rwlf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk, .we(ld_we), .waddr(ld_addr), .wdata(s_tdata[63:32]), .raddr(rd_addr), .rdata(y_rd));
	rwlf_ram #(.WIDTH(WGT_W), .DEPTH(MAX_POINTS)) u_pw_ram (
		.clk, .we(ld_we), .waddr(ld_addr), .wdata(s_tdata[87:64]), .raddr(rd_addr), .rdata(pw_rd));
	rwlf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_res_ram (
		.clk, .we(res_we), .waddr(rd_addr), .wdata(res_wd), .raddr(rd_addr), .rdata(res_rd));
	rwlf_ram #(.WIDTH(WGT_W), .DEPTH(MAX_POINTS)) u_ww_ram (
		.clk, .we(ww_we), .waddr(rd_addr), .wdata(ww_wd), .raddr(rd_addr), .rdata(ww_rd));

	rwlf_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(prod));
	rwlf_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	// point walk and arithmetic helpers
	always_comb begin
		i_nx    = i_q + CNT_W'(1);
		last_pt = (i_nx == n_q);
		k_init  = n_q[0] ? (n_q >> 1) : ((n_q >> 1) - CNT_W'(1));
		dx_c    = {x_q[VAL_W-1], x_q} - {xm_q[VAL_W-1], xm_q};
		dy_c    = {y_q[VAL_W-1], y_q} - {ym_q[VAL_W-1], ym_q};
		// truncated product term b*x/2^16 or b*xm/2^16
		sm_neg  = b_q[VAL_W-1] ^ ((state_q == ST_ICPT) ? xm_q[VAL_W-1] : x_q[VAL_W-1]);
		sm_c    = sm_neg ? -{2'b00, prod[63:16]} : {2'b00, prod[63:16]};
		icpt_c  = sext_f(ym_q) - sm_c;
		f_c     = sext_f(a_q) + sm_c;
		d_c     = sext_f(y_q) - f_q;
		d_abs   = d_c[F_W-1] ? -d_c : d_c;
		r_c     = (|d_abs[F_W-1:VAL_W]) ? '1 : d_abs[VAL_W-1:0];
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		med_sum = {1'b0, v1_q} + {1'b0, lo_q};
		med_c   = n_q[0] ? lo_q : med_sum[VAL_W:1];
		scale_c = {1'b0, med_c, 2'b00} + {2'b00, med_c, 1'b0};
		le_c    = (res_rd <= mid_q);
		cnt_nx  = cnt_q + CNT_W'(le_c);
		r_big   = ({3'b000, r_q} >= scale_q);
		acc0_abs = acc0_q[ACC_W-1] ? -acc0_q : acc0_q;
		acc1_abs = acc1_q[ACC_W-1] ? -acc1_q : acc1_q;
		sxy_sh   = {acc1_q[ACC_W-17:0], 16'h0000};
		sxy_abs  = sxy_sh[ACC_W-1] ? -sxy_sh : sxy_sh;
	end

	// multiplier operands and accumulator control per step
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		acc_en  = 1'b0;
		acc_sel = 1'b0;
		acc_hi  = 1'b0;
		acc_neg = 1'b0;
		case (state_q)
			ST_SUM: begin
				case (ph_q)
					4'd2: begin
						mul_a = MUL_W'(w_q);
						mul_b = MUL_W'(abs32(x_q));
					end
					4'd3: begin
						acc_en  = 1'b1;
						acc_neg = x_q[VAL_W-1];
						mul_a   = MUL_W'(w_q);
						mul_b   = MUL_W'(abs32(y_q));
					end
					4'd4: begin
						acc_en  = 1'b1;
						acc_sel = 1'b1;
						acc_neg = y_q[VAL_W-1];
					end
					default: ;
				endcase
			end
			ST_VAR: begin
				case (ph_q)
					4'd3: begin
						mul_a = MUL_W'(w_q);
						mul_b = MUL_W'(dxm_q);
					end
					4'd4: begin
						mul_a = prod[MUL_W-1:0];
						mul_b = MUL_W'(dxm_q);
					end
					4'd5: begin
						acc_en = 1'b1;
						mul_a  = MUL_W'(wdx_q[56:33]);
						mul_b  = MUL_W'(dxm_q);
					end
					4'd6: begin
						acc_en = 1'b1;
						acc_hi = 1'b1;
						mul_a  = wdx_q[32:0];
						mul_b  = MUL_W'(dym_q);
					end
					4'd7: begin
						acc_en  = 1'b1;
						acc_sel = 1'b1;
						acc_neg = dxn_q ^ dyn_q;
						mul_a   = MUL_W'(wdx_q[56:33]);
						mul_b   = MUL_W'(dym_q);
					end
					4'd8: begin
						acc_en  = 1'b1;
						acc_sel = 1'b1;
						acc_hi  = 1'b1;
						acc_neg = dxn_q ^ dyn_q;
					end
					default: ;
				endcase
			end
			ST_ICPT: begin
				mul_a = MUL_W'(abs32(b_q));
				mul_b = MUL_W'(abs32(xm_q));
			end
			ST_RESID: begin
				mul_a = MUL_W'(abs32(b_q));
				mul_b = MUL_W'(abs32(x_q));
			end
			ST_BISQ: begin
				case (ph_q)
					4'd4, 4'd6: begin
						mul_a = t_q;
						mul_b = t_q;
					end
					4'd7: begin
						mul_a = MUL_W'(pw_q);
						mul_b = prod[64:32];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		acc_sh   = acc_hi ? {{(ACC_W-PROD_W-MUL_W){1'b0}}, prod, {MUL_W{1'b0}}}
		                  : {{(ACC_W-PROD_W){1'b0}}, prod};
		acc_term = acc_neg ? -acc_sh : acc_sh;
		acc_sum  = (acc_sel ? acc1_q : acc0_q) + acc_term;
	end

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_MEAN: begin
				div_req.den   = {{(DIV_W-SW_W){1'b0}}, sw_q};
				div_req.iters = ITER_FULL;
				if (ph_q == 4'd0) begin
					div_req.start = 1'b1;
					div_req.num   = acc0_abs;
				end else if (ph_q == 4'd2) begin
					div_req.start = 1'b1;
					div_req.num   = acc1_abs;
				end
			end
			ST_SLOPE: begin
				div_req.start = (ph_q == 4'd0);
				div_req.num   = sxy_abs;
				div_req.den   = acc0_q;
				div_req.iters = ITER_FULL;
			end
			ST_BISQ: begin
				// u = r * 2^32 / scale, a 64-bit dividend fed from the top
				div_req.start = (ph_q == 4'd2) && !r_big;
				div_req.num   = {r_q, {(DIV_W-VAL_W){1'b0}}};
				div_req.den   = {{(DIV_W-SCALE_W){1'b0}}, scale_q};
				div_req.iters = ITER_FRAC;
			end
			default: ;
		endcase
	end

	// store writes during the residual and bisquare walks
	assign res_we = (state_q == ST_RESID) && (ph_q == 4'd4);
	assign res_wd = r_c;
	assign ww_we  = (state_q == ST_BISQ) && (((ph_q == 4'd2) && r_big) || (ph_q == 4'd8));
	assign ww_wd  = (ph_q == 4'd8) ? prod[55:32] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= '0;
			i_q        <= '0;
			n_q        <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			passes_q   <= RESET_PASSES;
			left_q     <= '0;
			use_ww_q   <= 1'b0;
			ok_q       <= 1'b0;
			second_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			xm_q       <= '0;
			ym_q       <= '0;
			a_q        <= '0;
			b_q        <= '0;
			dxm_q      <= '0;
			dym_q      <= '0;
			r_q        <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			v1_q       <= '0;
			w_q        <= '0;
			pw_q       <= '0;
			dxn_q      <= 1'b0;
			dyn_q      <= 1'b0;
			neg_q      <= 1'b0;
			wdx_q      <= '0;
			acc0_q     <= '0;
			acc1_q     <= '0;
			sw_q       <= '0;
			f_q        <= '0;
			t_q        <= '0;
			scale_q    <= '0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				passes_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (acc_en) begin
				if (acc_sel) begin
					acc1_q <= acc_sum;
				end else begin
					acc0_q <= acc_sum;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (ld_we) begin
							n_q <= n_q + CNT_W'(1);
						end
						if (s_tlast) begin
							left_q   <= passes_q;
							use_ww_q <= 1'b0;
							state_q  <= ST_SUM;
							ph_q     <= '0;
							i_q      <= '0;
							acc0_q   <= '0;
							acc1_q   <= '0;
							sw_q     <= '0;
						end
					end
				end

				// weighted sums Sw, Swx, Swy
				ST_SUM: begin
					case (ph_q)
						4'd1: begin
							x_q  <= x_rd;
							y_q  <= y_rd;
							w_q  <= w_rd;
							ph_q <= 4'd2;
						end
						4'd3: begin
							sw_q <= sw_q + SW_W'(w_q);
							ph_q <= 4'd4;
						end
						4'd4: begin
							ph_q <= '0;
							i_q  <= i_nx;
							if (last_pt) begin
								i_q <= '0;
								if (sw_q == '0) begin
									ok_q    <= 1'b0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_MEAN;
								end
							end
						end
						default: ph_q <= ph_q + PH_W'(1);
					endcase
				end

				// xm and ym through the shared divider
				ST_MEAN: begin
					case (ph_q)
						4'd0: begin
							neg_q <= acc0_q[ACC_W-1];
							ph_q  <= 4'd1;
						end
						4'd1: begin
							if (div_rsp.done) begin
								xm_q <= div_sat(neg_q, div_rsp.quo, div_rsp.ovf);
								ph_q <= 4'd2;
							end
						end
						4'd2: begin
							neg_q <= acc1_q[ACC_W-1];
							ph_q  <= 4'd3;
						end
						default: begin
							if (div_rsp.done) begin
								ym_q    <= div_sat(neg_q, div_rsp.quo, div_rsp.ovf);
								state_q <= ST_VAR;
								ph_q    <= '0;
								acc0_q  <= '0;
								acc1_q  <= '0;
							end
						end
					endcase
				end

				// Sxx in acc0, Sxy in acc1; w*dx split across two multiplies
				ST_VAR: begin
					case (ph_q)
						4'd1: begin
							x_q  <= x_rd;
							y_q  <= y_rd;
							w_q  <= w_rd;
							ph_q <= 4'd2;
						end
						4'd2: begin
							dxm_q <= dx_c[VAL_W] ? (~dx_c[VAL_W-1:0] + VAL_W'(1)) : dx_c[VAL_W-1:0];
							dym_q <= dy_c[VAL_W] ? (~dy_c[VAL_W-1:0] + VAL_W'(1)) : dy_c[VAL_W-1:0];
							dxn_q <= dx_c[VAL_W];
							dyn_q <= dy_c[VAL_W];
							ph_q  <= 4'd3;
						end
						4'd4: begin
							wdx_q <= prod[56:0];
							ph_q  <= 4'd5;
						end
						4'd8: begin
							ph_q <= '0;
							i_q  <= i_nx;
							if (last_pt) begin
								i_q <= '0;
								if (acc_sum == '0 && acc0_q == '0) begin
									ok_q    <= 1'b0;
									state_q <= ST_DONE;
								end else if (acc0_q == '0) begin
									ok_q    <= 1'b0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SLOPE;
								end
							end
						end
						default: ph_q <= ph_q + PH_W'(1);
					endcase
				end

				ST_SLOPE: begin
					if (ph_q == 4'd0) begin
						neg_q <= sxy_sh[ACC_W-1];
						ph_q  <= 4'd1;
					end else if (div_rsp.done) begin
						b_q     <= div_sat(neg_q, div_rsp.quo, div_rsp.ovf);
						state_q <= ST_ICPT;
						ph_q    <= '0;
					end
				end

				ST_ICPT: begin
					if (ph_q == 4'd0) begin
						ph_q <= 4'd1;
					end else begin
						a_q  <= sat_f(icpt_c);
						ph_q <= '0;
						i_q  <= '0;
						if (left_q == '0) begin
							ok_q    <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							left_q  <= left_q - CFG_W'(1);
							state_q <= ST_RESID;
						end
					end
				end

				// absolute residuals into the residual store
				ST_RESID: begin
					case (ph_q)
						4'd1: begin
							x_q  <= x_rd;
							y_q  <= y_rd;
							ph_q <= 4'd2;
						end
						4'd3: begin
							f_q  <= f_c;
							ph_q <= 4'd4;
						end
						4'd4: begin
							ph_q <= '0;
							i_q  <= i_nx;
							if (last_pt) begin
								i_q      <= '0;
								k_q      <= k_init;
								second_q <= 1'b0;
								lo_q     <= '0;
								hi_q     <= '1;
								state_q  <= ST_MSTEP;
							end
						end
						default: ph_q <= ph_q + PH_W'(1);
					endcase
				end

				// bisection on value: count residuals at or below mid
				ST_MSTEP: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_sum[VAL_W:1];
						cnt_q   <= '0;
						i_q     <= '0;
						ph_q    <= '0;
						state_q <= ST_MCNT;
					end else if (!n_q[0] && !second_q) begin
						v1_q     <= lo_q;
						second_q <= 1'b1;
						k_q      <= k_q + CNT_W'(1);
						lo_q     <= '0;
						hi_q     <= '1;
					end else begin
						scale_q <= scale_c;
						i_q     <= '0;
						ph_q    <= '0;
						if (scale_c == '0) begin
							ok_q    <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BISQ;
						end
					end
				end

				ST_MCNT: begin
					if (ph_q == 4'd0) begin
						ph_q <= 4'd1;
					end else begin
						cnt_q <= cnt_nx;
						ph_q  <= '0;
						i_q   <= i_nx;
						if (last_pt) begin
							i_q     <= '0;
							state_q <= ST_MSTEP;
							if (cnt_nx >= k_q + CNT_W'(1)) begin
								hi_q <= mid_q;
							end else begin
								lo_q <= mid_q + VAL_W'(1);
							end
						end
					end
				end

				// bisquare reweighting into the working weight store
				ST_BISQ: begin
					case (ph_q)
						4'd1: begin
							r_q  <= res_rd;
							pw_q <= pw_rd;
							ph_q <= 4'd2;
						end
						4'd2: begin
							if (r_big) begin
								ph_q <= '0;
								i_q  <= i_nx;
							end else begin
								ph_q <= 4'd3;
							end
						end
						4'd3: begin
							if (div_rsp.done) begin
								t_q  <= {1'b0, div_rsp.quo};
								ph_q <= 4'd4;
							end
						end
						4'd5: begin
							t_q  <= MUL_W'(34'h1_0000_0000 - {2'b00, prod[63:32]});
							ph_q <= 4'd6;
						end
						4'd8: begin
							ph_q <= '0;
							i_q  <= i_nx;
						end
						default: ph_q <= ph_q + PH_W'(1);
					endcase
					if (((ph_q == 4'd2) && r_big) || (ph_q == 4'd8)) begin
						if (last_pt) begin
							i_q      <= '0;
							use_ww_q <= 1'b1;
							acc0_q   <= '0;
							acc1_q   <= '0;
							sw_q     <= '0;
							state_q  <= ST_SUM;
						end
					end
				end

				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= ok_q ? {b_q, a_q} : '0;
						m_tuser_q  <= !ok_q;
						n_q        <= '0;
						i_q        <= '0;
						ph_q       <= '0;
						state_q    <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!m_tvalid_q || m_tready) |=> m_tvalid_q && (state_q == ST_IDLE))
		else $error("finished fit did not reach the output register");

	a_scale_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BISQ) |-> (scale_q != '0))
		else $error("bisquare walk with zero scale");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (n_q != '0) && (n_q <= CNT_W'(MAX_POINTS)))
		else $error("point count out of range during fit");

endmodule

>>> verif/robust_weighted_line_fit_unit_tb.sv
// Testbench for robust_weighted_line_fit_unit: streams point sets, predicts each fit
// with a behavioral bisquare IRLS model and checks every result field.
// Depends on rtl/rwlf_pkg.sv and rtl/robust_weighted_line_fit_unit.sv.
module robust_weighted_line_fit_unit_tb;
	import rwlf_pkg::*;

	typedef struct {
		logic [VAL_W-1:0] intercept;
		logic [VAL_W-1:0] slope;
		logic             fit_status;
	} line_fit_t;

	// set kinds for the random part
	typedef enum int {
		SET_NOISY_LINE,
		SET_FULL_RANGE,
		SET_EXACT_LINE,
		SET_ZERO_WEIGHT,
		SET_CONST_X
	} set_kind_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_data;

	// shadow of the block: stored points and the pass count
	int               pt_x[$];
	int               pt_y[$];
	int unsigned      pt_w[$];
	int unsigned      passes_shadow;
	line_fit_t        pending_fits[$];

	int               send_idle_pct;
	int               recv_idle_pct;
	int               fail_count;

	robust_weighted_line_fit_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // x_value[31:0], y_value[63:32], weight[87:64]
		.s_tlast  (s_tlast),   // last_point
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // intercept[31:0], slope[63:32]
		.m_tuser  (m_tuser),   // fit_status
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clamp a wide signed value to a 32-bit signed word.
	function automatic int clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -128'sd2147483648) return 32'h8000_0000;
		return int'(v[31:0]);
	endfunction

	// Weighted least-squares line over the stored points; 0 on a degenerate set.
	function automatic bit wls_line(input int unsigned w[$], output int alpha, output int beta);
		logic signed [127:0] sw, swx, swy, sxx, sxy, wv, xv, yv, xm, ym, dx, dy, bt;
		sw = 0; swx = 0; swy = 0; sxx = 0; sxy = 0;
		alpha = 0;
		beta = 0;
		for (int i = 0; i < pt_x.size(); i++) begin
			wv = w[i];
			xv = pt_x[i];
			yv = pt_y[i];
			sw += wv;
			swx += wv * xv;
			swy += wv * yv;
		end
		if (sw == 0) return 1'b0;
		xm = clamp32(swx / sw);
		ym = clamp32(swy / sw);
		for (int i = 0; i < pt_x.size(); i++) begin
			wv = w[i];
			xv = pt_x[i];
			yv = pt_y[i];
			dx = xv - xm;
			dy = yv - ym;
			sxx += wv * dx * dx;
			sxy += wv * dx * dy;
		end
		if (sxx == 0) return 1'b0;
		bt = clamp32((sxy <<< 16) / sxx);
		beta = int'(bt[31:0]);
		alpha = clamp32(ym - (bt * xm) / 65536);
		return 1'b1;
	endfunction

	// Full robust fit: plain fit, then up to passes_shadow bisquare passes, ending early at zero scale or a failed fit.
	function automatic line_fit_t predict_fit();
		line_fit_t          res;
		int                 a, b, n;
		bit                 ok;
		longint unsigned    resid[$];
		longint unsigned    med, sc, u, u2, t, t2;
		int unsigned        ww[$];
		logic signed [127:0] f, d;
		n = pt_x.size();
		ok = wls_line(pt_w, a, b);
		for (int p = 0; ok && p < passes_shadow; p++) begin
			resid.delete();
			for (int i = 0; i < n; i++) begin
				f = 128'(signed'(a)) + (128'(signed'(b)) * 128'(signed'(pt_x[i]))) / 65536;
				d = 128'(signed'(pt_y[i])) - f;
				if (d < 0) d = -d;
				resid.push_back(d > 128'sh0FFFF_FFFF ? 64'hFFFF_FFFF : longint'(d[63:0]));
			end
			ww.delete();
			begin
				longint unsigned srt[$];
				srt = resid;
				srt.sort();
				if (n % 2) med = srt[n / 2];
				else med = (srt[n / 2 - 1] + srt[n / 2]) >> 1;
			end
			sc = 6 * med;
			if (sc == 0) break;
			for (int i = 0; i < n; i++) begin
				if (resid[i] >= sc) begin
					ww.push_back(0);
				end else begin
					u = (resid[i] << 32) / sc;
					u2 = (u * u) >> 32;
					t = 64'h1_0000_0000 - u2;
					t2 = (t == 64'h1_0000_0000) ? t : (t * t) >> 32;
					ww.push_back(int'((longint'(pt_w[i]) * t2) >> 32));
				end
			end
			ok = wls_line(ww, a, b);
		end
		res.intercept = ok ? a : 0;
		res.slope = ok ? b : 0;
		res.fit_status = !ok;
		return res;
	endfunction

	// Store one accepted point and predict the fit when it closes the set.
	function automatic void absorb_point(input int x, input int y, input int unsigned w,
		input bit last);
		if (pt_x.size() < MAX_POINTS) begin
			pt_x.push_back(x);
			pt_y.push_back(y);
			pt_w.push_back(w);
		end
		if (last) begin
			pending_fits.push_back(predict_fit());
			pt_x.delete();
			pt_y.delete();
			pt_w.delete();
		end
	endfunction

	// Send one point; valid stays high afterwards until the next point or release.
	task automatic send_point(input int x, input int y, input int unsigned w, input bit last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {w[WGT_W-1:0], y, x};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_point(x, y, w, last);
	endtask

	// Drop valid and hold until every predicted fit has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_fits.size() != 0) @(posedge clk);
	endtask

	task automatic write_passes(input int unsigned v);
		drain();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		passes_shadow = v;
	endtask

	// Receiver: check each accepted result, then pick the next ready.
	always @(posedge clk) begin
		line_fit_t exp_fit;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fits.size() == 0) begin
				$error("unexpected result intercept=%h slope=%h", m_tdata[31:0], m_tdata[63:32]);
				fail_count++;
			end else begin
				exp_fit = pending_fits.pop_front();
				if (m_tdata[31:0] !== exp_fit.intercept) begin
					$error("intercept expected %h actual %h", exp_fit.intercept, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[63:32] !== exp_fit.slope) begin
					$error("slope expected %h actual %h", exp_fit.slope, m_tdata[63:32]);
					fail_count++;
				end
				if (m_tuser !== exp_fit.fit_status) begin
					$error("fit_status expected %b actual %b", exp_fit.fit_status, m_tuser);
					fail_count++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Build and send one point set of the given kind and size.
	task automatic send_set(input set_kind_t kind, input int n);
		longint a, b, xl, yl;
		int     x, y, cx;
		int unsigned w;
		a = longint'($signed($urandom)) >>> 8;
		b = longint'($signed($urandom)) >>> 12;
		cx = $signed($urandom) >>> 8;
		for (int i = 0; i < n; i++) begin
			xl = longint'($signed($urandom)) >>> 10;
			w = $urandom_range(1, 24'hFFFFFF);
			case (kind)
				SET_NOISY_LINE: begin
					yl = a + (b * xl) / 65536 + (longint'($signed($urandom)) >>> 18);
					if ($urandom_range(0, 9) == 0) yl += longint'($signed($urandom)) >>> 4;
				end
				SET_FULL_RANGE: begin
					xl = $signed($urandom);
					yl = $signed($urandom);
					w = $urandom_range(0, 24'hFFFFFF);
				end
				SET_EXACT_LINE: begin
					yl = a + (b * xl) / 65536;
				end
				SET_ZERO_WEIGHT: begin
					yl = $signed($urandom);
					w = 0;
				end
				default: begin
					xl = cx;
					yl = $signed($urandom);
				end
			endcase
			x = int'(xl);
			y = int'(yl);
			send_point(x, y, w, i == n - 1);
		end
	endtask

	// Extremes of every field, degenerate sets, a perfect line and an outlier line at reset passes.
	task automatic test_directed_sets();
		send_idle_pct = 26;
		recv_idle_pct = 59;
		// opposing extremes of x and y at full weight give a slope near minus one
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFFFFFF, 1'b0);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFFFFFF, 1'b1);
		// lone point has no x spread
		send_point(32'sh0001_0000, 32'sh0002_0000, 24'h010000, 1'b1);
		// all weights zero
		send_point(32'sh0001_0000, 32'sh0, 24'h0, 1'b0);
		send_point(32'sh0002_0000, 32'sh1, 24'h0, 1'b0);
		send_point(32'sh0003_0000, 32'sh2, 24'h0, 1'b1);
		// identical x
		send_point(32'sh0005_0000, 32'sh0001_0000, 24'h000001, 1'b0);
		send_point(32'sh0005_0000, -32'sh0001_0000, 24'h010000, 1'b0);
		send_point(32'sh0005_0000, 32'sh0, 24'hFFFFFF, 1'b1);
		// perfect line, residuals all zero so the passes stop early
		for (int i = 0; i < 5; i++)
			send_point(i <<< 16, (3 + 2 * i) <<< 16, 24'h010000, i == 4);
		// line with one gross outlier for the reweighting
		for (int i = 0; i < 6; i++)
			send_point(i <<< 16, i == 3 ? 32'sh0100_0000 : (i <<< 16) + 100,
				24'h008000 + i, i == 5);
		drain();
	endtask

	// One set that overruns the store: the full store still fits and the dropped
	// last point still fires.
	task automatic test_store_limits();
		write_passes(0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_set(SET_NOISY_LINE, MAX_POINTS + 6);
		drain();
	endtask

	// Random sets under one pass count and one idling mix.
	task automatic test_random_sets(input int unsigned passes, input int items, input int max_n,
		input int s_pct, input int r_pct);
		int sent, n, pick;
		set_kind_t kind;
		write_passes(passes);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			kind = pick < 70 ? SET_NOISY_LINE : pick < 80 ? SET_FULL_RANGE :
				pick < 90 ? SET_EXACT_LINE : pick < 95 ? SET_ZERO_WEIGHT : SET_CONST_X;
			n = $urandom_range(0, 19) == 0 ? 1 : $urandom_range(2, max_n);
			send_set(kind, n);
			sent += n;
			// hold the stream until the block has answered everything
			if ($urandom_range(0, 7) == 0) drain();
		end
		drain();
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		passes_shadow = RESET_PASSES;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_sets();
		test_store_limits();
		test_random_sets(15, 60, 6, 26, 59);
		test_random_sets(1, 150, 12, 59, 26);
		test_random_sets(0, 150, 16, 0, 0);
		test_random_sets(5, 150, 10, 26, 59);
		test_random_sets(3, 100, 10, 0, 0);

		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_fits.size() == 0) begin
			$display("robust_weighted_line_fit_unit_tb passed");
		end else begin
			$display("robust_weighted_line_fit_unit_tb failed");
		end
		$finish;
	end

	initial begin
		#300_000_000;
		$display("robust_weighted_line_fit_unit_tb failed");
		$finish;
	end

endmodule

>>> files.f
rtl/rwlf_pkg.sv
rtl/rwlf_ram.sv
rtl/rwlf_mul.sv
rtl/rwlf_div.sv
rtl/robust_weighted_line_fit_unit.sv
verif/robust_weighted_line_fit_unit_tb.sv
